// File: hdl/sdc_pkg.sv
// Shared types, constants and the digit glyph function for the radix digit converter.
package sdc_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int RADIX_BITS  = 32;
    localparam int CHAR_BITS   = 7;
    localparam int STEP_BITS   = $clog2(VALUE_BITS);
    localparam int ALPHA_BASES = 62;
    localparam logic [RADIX_BITS-1:0] MIN_RADIX  = 32'd2;
    localparam logic [RADIX_BITS-1:0] ALPHA_LIM  = 32'd62;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic rd;
        logic emit;
        logic inv;
    } cmd_t;

    typedef struct packed {
        logic radix_bad;
        logic div_done;
        logic quo_zero;
        logic full;
        logic rd_last;
        logic out_free;
    } sts_t;

    // 0-9, A-Z, a-z; anything past the alphabet maps to 0
    function automatic logic [CHAR_BITS-1:0] glyph(input logic [RADIX_BITS-1:0] d);
        logic [CHAR_BITS-1:0] lo;
        lo = d[CHAR_BITS-1:0];
        if (d < 32'd10)
            return lo + 7'd48;
        else if (d < 32'd36)
            return lo + 7'd55;
        else if (d < 32'd62)
            return lo + 7'd61;
        else
            return '0;
    endfunction

endpackage

// File: hdl/sdc_if.sv
// Valid/ready channel interfaces for input values and output digit beats.
interface sdc_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [31:0]        radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface sdc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digit_value;
    logic [6:0]  char_code;
    logic        negative;
    logic        invalid;
    logic        last;

    modport source (output valid, output digit_value, output char_code, output negative,
                    output invalid, output last, input ready);
    modport sink   (input valid, input digit_value, input char_code, input negative,
                    input invalid, input last, output ready);
endinterface

// File: hdl/signed_radix_digit_converter_top.sv
// Top level of the signed radix digit converter.
// Usage:
//   din  (sink)  : one beat carries a signed 64-bit value and a 32-bit radix.
//   dout (source): one beat per digit, most significant first; the first beat
//                  flags a negative value, the final beat has last set.
//   A radix below 2 yields one beat with invalid and last set.
// Sequence:
//   Each digit takes 64 restoring-division steps in the shared bit-serial
//   divider, then a write of the remainder to the digit RAM.
//   Emission reads the RAM with registered data: each digit is read in S_RD,
//   then moved to the output register in S_EMIT once that register frees.
//   An invalid radix goes to S_INV, which registers its beat once the output
//   register frees.
//   One value is in flight at a time; din.ready rises again once the last
//   beat sits in the output register.
// Reset: asynchronous, active low; returns to idle with no beat pending.
// Stall: dout holds its beat while dout.ready is low; the controller holds the
//   next digit, already read from the RAM, until the output register frees.
module signed_radix_digit_converter_top #(
    parameter int MAX_DIGITS = 64
) (
    input logic     clk,
    input logic     rst_n,
    sdc_in_if.sink  din,
    sdc_out_if.source dout
);
    import sdc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdc_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_value    (din.value),
        .in_radix    (din.radix),
        .out_ready   (dout.ready),
        .out_valid   (dout.valid),
        .digit_value (dout.digit_value),
        .char_code   (dout.char_code),
        .negative    (dout.negative),
        .invalid     (dout.invalid),
        .last        (dout.last)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> !din.ready)
        else $error("input taken while a value is in flight");

    a_invalid_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.invalid) |-> (dout.last && dout.digit_value == '0
            && dout.char_code == '0 && !dout.negative))
        else $error("malformed invalid beat");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.store, cmd.rd, cmd.emit, cmd.inv}))
        else $error("conflicting datapath commands");

    a_neg_then_not: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.ready && !dout.last) |=>
            (!(dout.valid && dout.negative)))
        else $error("negative flag past first beat");
endmodule

// File: hdl/sdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: hdl/sdc_ctrl.sv
// Controller state machine: sequences divide, store, read, emit and invalid-radix phases.
module sdc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sdc_pkg::sts_t sts,
    output sdc_pkg::cmd_t cmd
);
    import sdc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_INV   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.radix_bad ? S_INV : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = (sts.quo_zero || sts.full) ? S_RD : S_DIV;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.rd_last ? S_IDLE : S_RD;
                end
            end
            S_INV:
            begin
                if (sts.out_free)
                begin
                    cmd.inv    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// File: hdl/sdc_dp.sv
// Datapath: bit-serial divider, digit store and output beat register.
module sdc_dp #(
    parameter int MAX_DIGITS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sdc_pkg::cmd_t                          cmd,
    output sdc_pkg::sts_t                          sts,
    input  logic signed [sdc_pkg::VALUE_BITS-1:0]  in_value,
    input  logic [sdc_pkg::RADIX_BITS-1:0]         in_radix,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic [sdc_pkg::RADIX_BITS-1:0]         digit_value,
    output logic [sdc_pkg::CHAR_BITS-1:0]          char_code,
    output logic                                   negative,
    output logic                                   invalid,
    output logic                                   last
);
    import sdc_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [RADIX_BITS-1:0] rem_reg, rem_next;
    logic [RADIX_BITS-1:0] radix_reg, radix_next;
    logic                  neg_reg, neg_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [STEP_BITS-1:0]  bit_reg, bit_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic                  first_reg, first_next;
    logic                  ov_reg, ov_next;
    logic [RADIX_BITS-1:0] dv_reg, dv_next;
    logic [CHAR_BITS-1:0]  ch_reg, ch_next;
    logic                  ng_reg, ng_next;
    logic                  iv_reg, iv_next;
    logic                  ls_reg, ls_next;

    logic [RADIX_BITS:0]   shifted;
    logic [RADIX_BITS:0]   diff;
    logic                  ge;
    logic [VALUE_BITS-1:0] mag;
    logic [RADIX_BITS-1:0] ram_rdata;

    sdc_ram #(
        .WIDTH (RADIX_BITS),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (rem_reg),
        .re    (cmd.rd),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign mag     = in_value[VALUE_BITS-1] ? (~in_value + 64'd1) : in_value;
    assign shifted = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff    = shifted - {1'b0, radix_reg};
    assign ge      = shifted >= {1'b0, radix_reg};

    always_comb
    begin
        sts.radix_bad = in_radix < MIN_RADIX;
        sts.div_done  = bit_reg == STEP_BITS'(VALUE_BITS - 1);
        sts.quo_zero  = quo_reg == '0;
        sts.full      = cnt_reg == CW'(MAX_DIGITS - 1);
        sts.rd_last   = rd_ptr_reg == '0;
        sts.out_free  = !ov_reg || out_ready;
    end

    always_comb
    begin
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        radix_next  = radix_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        bit_next    = bit_reg;
        rd_ptr_next = rd_ptr_reg;
        first_next  = first_reg;
        dv_next     = dv_reg;
        ch_next     = ch_reg;
        ng_next     = ng_reg;
        iv_next     = iv_reg;
        ls_next     = ls_reg;
        ov_next     = ov_reg && !out_ready;

        if (cmd.load)
        begin
            quo_next   = mag;
            rem_next   = '0;
            radix_next = in_radix;
            neg_next   = in_value[VALUE_BITS-1];
            cnt_next   = '0;
            bit_next   = '0;
        end
        if (cmd.step)
        begin
            quo_next = {quo_reg[VALUE_BITS-2:0], ge};
            rem_next = ge ? diff[RADIX_BITS-1:0] : shifted[RADIX_BITS-1:0];
            bit_next = bit_reg + STEP_BITS'(1);
        end
        if (cmd.store)
        begin
            cnt_next    = cnt_reg + CW'(1);
            rd_ptr_next = cnt_reg[AW-1:0];
            first_next  = 1'b1;
            rem_next    = '0;
            bit_next    = '0;
        end
        if (cmd.emit)
        begin
            dv_next     = ram_rdata;
            ch_next     = (radix_reg <= ALPHA_LIM) ? glyph(ram_rdata) : '0;
            ng_next     = first_reg && neg_reg;
            iv_next     = 1'b0;
            ls_next     = sts.rd_last;
            ov_next     = 1'b1;
            first_next  = 1'b0;
            rd_ptr_next = rd_ptr_reg - AW'(1);
        end
        if (cmd.inv)
        begin
            dv_next = '0;
            ch_next = '0;
            ng_next = 1'b0;
            iv_next = 1'b1;
            ls_next = 1'b1;
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            bit_reg    <= '0;
            rd_ptr_reg <= '0;
            first_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            bit_reg    <= bit_next;
            rd_ptr_reg <= rd_ptr_next;
            first_reg  <= first_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        neg_reg   <= neg_next;
        dv_reg    <= dv_next;
        ch_reg    <= ch_next;
        ng_reg    <= ng_next;
        iv_reg    <= iv_next;
        ls_reg    <= ls_next;
    end

    assign out_valid   = ov_reg;
    assign digit_value = dv_reg;
    assign char_code   = ch_reg;
    assign negative    = ng_reg;
    assign invalid     = iv_reg;
    assign last        = ls_reg;
endmodule
